/* hw/rtl/float32_divider_unit_defines.svh */
// Assertion macros for the float32 divider unit.
// Used by the port checker; depends on nothing else.
`ifndef FLOAT32_DIVIDER_UNIT_DEFINES_SVH
`define FLOAT32_DIVIDER_UNIT_DEFINES_SVH

// Assert that a property holds, clocked and reset-qualified.
`define FDIV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that a property holds during reset, too.
`define FDIV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/fdiv_pkg.sv */
// Package for the float32 divider: payload types, status codes, constants.
// Depends on nothing.
package fdiv_pkg;

   localparam int FracBits = 23;
   localparam int ExpBits = 8;
   localparam int ExpBias = 127;
   localparam int ExpMaxField = 255;
   localparam int HiddenOne = 8388608;
   localparam int SigBits = FracBits + 1;
   localparam int QueueDepthDefault = 4;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_DIVZERO = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] dividend;
      logic [31:0] divisor;
   } req_type;

   typedef struct packed {
      logic [31:0] quotient;
      logic [1:0] status;
   } rsp_type;

   // Classified operation passed from front to back.
   typedef struct packed {
      logic divzero;
      logic numzero;
      logic sign;
      logic signed [9:0] exp;
      logic [SigBits-1:0] mnum;
      logic [SigBits-1:0] mden;
   } op_type;

endpackage

/* hw/rtl/float32_divider_unit.sv */
// Channel  | ports              | payload
// req      | req_valid/ready    | dividend, divisor
// rsp      | rsp_valid/ready    | quotient, status
//
// One item per cycle sustained while rsp is not stalled; an accepted item passes
// the front register, a queue entry, 24 divide stages (one quotient bit each)
// and the output register before rsp_valid rises.
// Reset is synchronous and clears valid bits, queue pointers and queue count only.
// A stall on rsp freezes the divide pipeline; the queue keeps the front open until it fills.
// Depends on fdiv_pkg, fdiv_front, fdiv_queue, fdiv_back.
module float32_divider_unit #(
   parameter int QueueDepth = fdiv_pkg::QueueDepthDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  fdiv_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output fdiv_pkg::rsp_type rsp_data
);
   import fdiv_pkg::*;

   logic f_valid, f_ready, b_valid, b_ready;
   op_type f_data, b_data;

   fdiv_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .op_valid(f_valid), .op_ready(f_ready), .op_data(f_data)
   );

   fdiv_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   fdiv_back u_back (
      .clock(clock), .reset(reset),
      .op_valid(b_valid), .op_ready(b_ready), .op_data(b_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule

/* hw/rtl/fdiv_front.sv */
// Front part: accepts items, classifies zeros, splits fields.
// Depends on fdiv_pkg.
module fdiv_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  fdiv_pkg::req_type req_data,
   output logic op_valid,
   input  logic op_ready,
   output fdiv_pkg::op_type op_data
);
   import fdiv_pkg::*;

   logic valid_ff, valid_in;
   op_type op_ff, op_in;
   logic [ExpBits-1:0] en, ed;

   assign req_ready = !valid_ff || op_ready;
   assign en = req_data.dividend[30:23];
   assign ed = req_data.divisor[30:23];

   always_comb begin
      op_in.divzero = (req_data.divisor == 32'd0);
      op_in.numzero = (req_data.dividend == 32'd0);
      op_in.sign = req_data.dividend[31] ^ req_data.divisor[31];
      op_in.exp = $signed({2'b00, en}) - $signed({2'b00, ed}) + 10'sd127;
      op_in.mnum = {1'b1, req_data.dividend[FracBits-1:0]};
      op_in.mden = {1'b1, req_data.divisor[FracBits-1:0]};
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         op_ff <= op_in;
      end
   end

   assign op_valid = valid_ff;
   assign op_data = op_ff;
endmodule

/* hw/rtl/fdiv_queue.sv */
// Short queue between front and back parts.
// Depends on fdiv_pkg.
module fdiv_queue #(
   parameter int Depth = fdiv_pkg::QueueDepthDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  fdiv_pkg::op_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output fdiv_pkg::op_type out_data
);
   import fdiv_pkg::*;

   localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;

   op_type mem_ff [Depth];
   logic [AddrBits-1:0] wr_ff, rd_ff;
   logic [AddrBits:0] count_ff;
   logic push, pop;

   assign in_ready = (count_ff != Depth[AddrBits:0]);
   assign out_valid = (count_ff != '0);
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AddrBits'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AddrBits'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + {{AddrBits{1'b0}}, push} - {{AddrBits{1'b0}}, pop};
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end
endmodule

/* hw/rtl/fdiv_back.sv */
// Back part: pipelined restoring significand divide, normalize, range check.
// Depends on fdiv_pkg.
module fdiv_back (
   input  logic clock,
   input  logic reset,
   input  logic op_valid,
   output logic op_ready,
   input  fdiv_pkg::op_type op_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output fdiv_pkg::rsp_type rsp_data
);
   import fdiv_pkg::*;

   // One quotient bit per stage: dividend is mnum << 23, quotient 24 bits.
   localparam int Stages = SigBits;
   localparam int RemBits = SigBits + 1;

   logic valid_ff [Stages+1];
   op_type op_ff [Stages+1];
   logic [RemBits-1:0] rem_ff [Stages+1];
   logic [SigBits-1:0] q_ff [Stages+1];
   logic [SigBits-1:0] num_ff [Stages+1];
   logic advance;
   logic out_valid_ff;
   rsp_type out_ff, out_in;

   // Whole pipeline moves when the output slot is free or drained.
   assign advance = !out_valid_ff || rsp_ready;
   assign op_ready = advance;

   // Preload the remainder with mnum >> 1 and keep mnum's low bit as the next
   // bit to bring down, so stage 0 compares mnum itself and later stages
   // bring down the 23 zero bits of mnum << 23.
   assign valid_ff[0] = op_valid;
   assign op_ff[0] = op_data;
   assign rem_ff[0] = {2'b00, op_data.mnum[SigBits-1:1]};
   assign q_ff[0] = '0;
   assign num_ff[0] = {op_data.mnum[0], {FracBits{1'b0}}};

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [RemBits-1:0] trial;
      logic [RemBits-1:0] sub;
      logic fits;
      logic [RemBits-1:0] rem_s_ff;
      logic [SigBits-1:0] q_s_ff, num_s_ff;
      logic valid_s_ff;
      op_type op_s_ff;

      // Bring down next dividend bit: low bit of mnum first, then zeros.
      assign trial = {rem_ff[s][RemBits-2:0], num_ff[s][SigBits-1]};
      assign sub = trial - {1'b0, op_ff[s].mden};
      assign fits = (trial >= {1'b0, op_ff[s].mden});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_s_ff <= 1'b0;
         end else if (advance) begin
            valid_s_ff <= valid_ff[s];
         end
         if (advance) begin
            op_s_ff <= op_ff[s];
            rem_s_ff <= fits ? sub : trial;
            q_s_ff <= {q_ff[s][SigBits-2:0], fits};
            num_s_ff <= {num_ff[s][SigBits-2:0], 1'b0};
         end
      end

      assign valid_ff[s+1] = valid_s_ff;
      assign op_ff[s+1] = op_s_ff;
      assign rem_ff[s+1] = rem_s_ff;
      assign q_ff[s+1] = q_s_ff;
      assign num_ff[s+1] = num_s_ff;
   end

   // The raw quotient lies in [2^22, 2^24), so 24 bits hold it and one
   // left shift normalizes it.
   logic [SigBits-1:0] qfin;
   logic signed [9:0] efin;
   op_type opl;

   always_comb begin
      opl = op_ff[Stages];
      qfin = q_ff[Stages];
      efin = opl.exp;
      if (!qfin[SigBits-1]) begin
         qfin = {qfin[SigBits-2:0], 1'b0};
         efin = opl.exp - 10'sd1;
      end
      out_in.quotient = '0;
      out_in.status = ST_OK;
      if (opl.divzero) begin
         out_in.status = ST_DIVZERO;
      end else if (opl.numzero) begin
         out_in.status = ST_OK;
      end else if (efin > 10'sd254) begin
         out_in.status = ST_OVERFLOW;
      end else if (efin < 10'sd1) begin
         out_in.status = ST_UNDERFLOW;
      end else begin
         out_in.quotient = {opl.sign, efin[ExpBits-1:0], qfin[FracBits-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[Stages];
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
endmodule

/* hw/rtl/fdiv_checker.sv */
// Port checker for the float32 divider unit, bound to the top level.
// Depends on fdiv_pkg and float32_divider_unit_defines.svh.
`include "float32_divider_unit_defines.svh"
module fdiv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input fdiv_pkg::req_type req_data,
   input logic rsp_valid,
   input logic rsp_ready,
   input fdiv_pkg::rsp_type rsp_data
);
   import fdiv_pkg::*;

   `FDIV_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp not held")
   `FDIV_ASSERT(a_err_zero, clock, reset,
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.quotient == 32'd0, "error word")
   `FDIV_ASSERT(a_ok_exp, clock, reset,
      rsp_valid && rsp_data.quotient != 32'd0 |-> rsp_data.quotient[30:23] != 8'd0
      && rsp_data.quotient[30:23] != 8'hff, "exponent out of range")
   `FDIV_ASSERT_ALWAYS(a_reset_idle, clock,
      $fell(reset) |-> !rsp_valid, "rsp valid after reset")
endmodule

bind float32_divider_unit fdiv_checker u_fdiv_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
